// ===== src/periodic_waveform_generator_macros.svh =====
// Assertion macros for the periodic waveform generator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef PERIODIC_WAVEFORM_GENERATOR_MACROS_SVH
`define PERIODIC_WAVEFORM_GENERATOR_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define PWG_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Implication checked at every clock edge outside reset.
`define PWG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/pwg_pkg.sv =====
// Shared types and constants for the periodic waveform generator.
// No dependencies; used by the top level, the phase divider and the checker.
package pwg_pkg;

    // Width of the time and period values and of the Q16.16 levels.
    localparam int TIME_W  = 32;
    localparam int LEVEL_W = 32;

    // Waveform select codes; codes above gravity produce zero.
    typedef enum logic [2:0] {
        WAVE_TRIANGLE = 3'd0,
        WAVE_SQUARE   = 3'd1,
        WAVE_SINE     = 3'd2,
        WAVE_SAWTOOTH = 3'd3,
        WAVE_GRAVITY  = 3'd4
    } wave_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_WAVEFORM  = 2'd0,
        REG_MIN_LEVEL = 2'd1,
        REG_MAX_LEVEL = 2'd2,
        REG_PERIOD    = 2'd3
    } cfg_reg_t;

    // Register values after reset.
    localparam logic [2:0]         WAVE_RESET   = 3'd0;
    localparam logic [LEVEL_W-1:0] MIN_RESET    = 32'd0;
    localparam logic [LEVEL_W-1:0] MAX_RESET    = 32'd65536;
    localparam logic [TIME_W-1:0]  PERIOD_RESET = 32'd1000000;

    // Gravity saturates at 1.0 in Q16.16.
    localparam logic [LEVEL_W-1:0] GRAVITY_ONE = 32'd65536;

    // Quarter-wave sine polynomial, all values in Q30.
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [30:0] SIN_C11 = 31'd3864;
    localparam int          HORNER_N = 5;
    // Horner coefficients in order of use: c9, c7, c5, c3, c1.
    localparam logic [30:0] SIN_HORNER [HORNER_N] = '{
        31'd172272, 31'd5026995, 31'd85569306, 31'd693598669, 31'd1686629713
    };

endpackage

// ===== src/pwg_phase_div.sv =====
// Pipelined restoring divider forming the phase fraction of the time in a period.
// Depends on pwg_pkg; instantiated by periodic_waveform_generator.
module pwg_phase_div #(
    parameter int PHASE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [pwg_pkg::TIME_W-1:0] dividend,
    input  logic [pwg_pkg::TIME_W-1:0] divisor,
    output logic                       out_valid,
    output logic [PHASE_BITS-1:0]      quotient
);
    import pwg_pkg::*;

    // One quotient bit per stage over the dividend bits, then PHASE_BITS
    // fraction bits. The remainder after the integer bits is time mod period,
    // so the last PHASE_BITS quotient bits are the phase.
    localparam int STAGES = TIME_W + PHASE_BITS;

    logic                  vld_in   [STAGES];
    logic [TIME_W-1:0]     rem_in   [STAGES];
    logic [TIME_W-1:0]     num_in   [STAGES];
    logic [PHASE_BITS-1:0] quo_in   [STAGES];

    logic                  vld_reg  [STAGES];
    logic [TIME_W-1:0]     rem_reg  [STAGES];
    logic [TIME_W-1:0]     num_reg  [STAGES];
    logic [PHASE_BITS-1:0] quo_reg  [STAGES];

    logic [TIME_W-1:0]     rem_next [STAGES];
    logic [TIME_W-1:0]     num_next [STAGES];
    logic [PHASE_BITS-1:0] quo_next [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        // Stage inputs come from the request or from the previous stage.
        if (s == 0)
        begin : g_first
            assign vld_in[s] = in_valid;
            assign rem_in[s] = '0;
            assign num_in[s] = dividend;
            assign quo_in[s] = '0;
        end
        else
        begin : g_next
            assign vld_in[s] = vld_reg[s-1];
            assign rem_in[s] = rem_reg[s-1];
            assign num_in[s] = num_reg[s-1];
            assign quo_in[s] = quo_reg[s-1];
        end

        // Shift in the next dividend bit and subtract the divisor if it fits.
        always_comb
        begin
            logic [TIME_W:0] trial;
            logic            fits;
            trial       = {rem_in[s], num_in[s][TIME_W-1]};
            fits        = (trial >= {1'b0, divisor});
            rem_next[s] = fits ? TIME_W'(trial - {1'b0, divisor}) : trial[TIME_W-1:0];
            num_next[s] = {num_in[s][TIME_W-2:0], 1'b0};
            quo_next[s] = {quo_in[s][PHASE_BITS-2:0], fits};
        end

        // Valid bit of this stage.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_in[s];
            end
        end

        // Data of this stage.
        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next[s];
            num_reg[s] <= num_next[s];
            quo_reg[s] <= quo_next[s];
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign quotient  = quo_reg[STAGES-1];

endmodule

// ===== src/periodic_waveform_generator.sv =====
// A request accepted at a clock edge passes through 32 + PHASE_BITS divider
// stages that form the phase, then 15 stages for the sine polynomial, the level
// mapping and the output, and then gives its strobe.
// Throughput: one request per cycle, every cycle; busy is never raised.
// Reset (rst_n low, asynchronous) empties the pipeline and restores the
// registers: triangle, minimum 0, maximum 1.0, period 1000000 us.
module periodic_waveform_generator #(
    parameter int PHASE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [pwg_pkg::TIME_W-1:0]         time_micros,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [pwg_pkg::LEVEL_W-1:0]        cfg_wdata,
    output logic                               done,
    output logic signed [pwg_pkg::LEVEL_W-1:0] wave_value
);
    import pwg_pkg::*;

    localparam int PB = PHASE_BITS;
    localparam logic [PB:0]   PHASE_ONE  = (PB+1)'(1) << PB;
    localparam logic [PB-1:0] PHASE_HALF = PB'(1) << (PB - 1);

    // Sine table addressing: k = phase * depth >> PB, u = k * 2^32 / depth.
    localparam int DW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int KW = $clog2(SINE_TABLE_DEPTH);
    localparam int NW = TIME_W + DW;
    localparam int RW = TIME_W + 1;
    localparam logic [DW-1:0] DEPTH_C    = DW'(SINE_TABLE_DEPTH);
    localparam logic [63:0]   RECIP_FULL = (64'd1 << (TIME_W + KW)) / 64'(SINE_TABLE_DEPTH);
    localparam logic [RW-1:0] RECIP      = RW'(RECIP_FULL);

    // Rescaling of the Q31 sine entry and gravity rounding shift.
    localparam int EW      = TIME_W + PB + 1;
    localparam int GRAV_SH = 2 * PB - 18;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0]         waveform_select_reg, waveform_select_next;
    logic [LEVEL_W-1:0] minimum_level_reg, minimum_level_next;
    logic [LEVEL_W-1:0] maximum_level_reg, maximum_level_next;
    logic [TIME_W-1:0]  period_micros_reg, period_micros_next;

    // Register writes by index; other registers keep their value.
    always_comb
    begin
        waveform_select_next = waveform_select_reg;
        minimum_level_next   = minimum_level_reg;
        maximum_level_next   = maximum_level_reg;
        period_micros_next   = period_micros_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_WAVEFORM:  waveform_select_next = cfg_wdata[2:0];
                REG_MIN_LEVEL: minimum_level_next   = cfg_wdata;
                REG_MAX_LEVEL: maximum_level_next   = cfg_wdata;
                REG_PERIOD:    period_micros_next   = cfg_wdata;
                default:       ;
            endcase
        end
    end

    // Span of the output range as sign and magnitude, refreshed every cycle.
    logic               span_neg_reg, span_neg_next;
    logic [LEVEL_W-1:0] span_mag_reg, span_mag_next;

    always_comb
    begin
        logic [LEVEL_W:0] diff;
        diff          = {maximum_level_reg[LEVEL_W-1], maximum_level_reg}
                      - {minimum_level_reg[LEVEL_W-1], minimum_level_reg};
        span_neg_next = diff[LEVEL_W];
        span_mag_next = diff[LEVEL_W] ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_select_reg <= WAVE_RESET;
            minimum_level_reg   <= MIN_RESET;
            maximum_level_reg   <= MAX_RESET;
            period_micros_reg   <= PERIOD_RESET;
            span_neg_reg        <= 1'b0;
            span_mag_reg        <= MAX_RESET;
        end
        else
        begin
            waveform_select_reg <= waveform_select_next;
            minimum_level_reg   <= minimum_level_next;
            maximum_level_reg   <= maximum_level_next;
            period_micros_reg   <= period_micros_next;
            span_neg_reg        <= span_neg_next;
            span_mag_reg        <= span_mag_next;
        end
    end

    // The pipeline never stalls, so every request is taken.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Phase: (time mod period) / period as a PB-bit fraction
    // ------------------------------------------------------------------
    logic          div_valid;
    logic [PB-1:0] div_quo;
    logic [PB-1:0] phase;

    pwg_phase_div #(
        .PHASE_BITS (PB)
    ) u_phase_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .dividend  (time_micros),
        .divisor   (period_micros_reg),
        .out_valid (div_valid),
        .quotient  (div_quo)
    );

    // A zero period yields a zero phase.
    assign phase = (period_micros_reg == '0) ? '0 : div_quo;

    // ------------------------------------------------------------------
    // Sine table address
    // ------------------------------------------------------------------
    logic              k_vld_reg;
    logic [PB-1:0]     k_phase_reg;
    logic [KW-1:0]     k_reg, k_next;

    logic              kr_vld_reg;
    logic [PB-1:0]     kr_phase_reg;
    logic [KW-1:0]     kr_k_reg;
    logic [KW+RW-1:0]  kr_reg, kr_next;

    logic              qd_vld_reg;
    logic [PB-1:0]     qd_phase_reg;
    logic [KW-1:0]     qd_k_reg;
    logic [TIME_W-1:0] qd_q0_reg, qd_q0_next;
    logic [NW-1:0]     qd_reg, qd_next;

    logic              u_vld_reg;
    logic [PB-1:0]     u_phase_reg;
    logic [TIME_W-1:0] u_reg, u_next;

    // Table index from the phase.
    always_comb
    begin
        logic [PB+DW-1:0] prod;
        prod   = (PB+DW)'(phase) * (PB+DW)'(DEPTH_C);
        k_next = prod[PB +: KW];
    end

    // Quotient estimate of k * 2^32 / depth by the reciprocal.
    assign kr_next = (KW+RW)'(k_reg) * (KW+RW)'(RECIP);

    // Back-multiply the estimate for the remainder check.
    always_comb
    begin
        qd_q0_next = kr_reg[KW +: TIME_W];
        qd_next    = NW'(qd_q0_next) * NW'(DEPTH_C);
    end

    // The estimate is at most one low; correct it.
    always_comb
    begin
        logic [NW-1:0] rem;
        rem    = {(NW-TIME_W)'(qd_k_reg), {TIME_W{1'b0}}} - qd_reg;
        u_next = (rem >= NW'(DEPTH_C)) ? qd_q0_reg + 1'b1 : qd_q0_reg;
    end

    // ------------------------------------------------------------------
    // Quarter-wave reduction and polynomial
    // ------------------------------------------------------------------
    logic          x_vld_reg;
    logic [PB-1:0] x_phase_reg;
    logic [1:0]    x_quad_reg;
    logic [30:0]   x_reg, x_next;

    logic          x2_vld_reg;
    logic [PB-1:0] x2_phase_reg;
    logic [1:0]    x2_quad_reg;
    logic [30:0]   x2_x_reg;
    logic [30:0]   x2_reg, x2_next;

    // Fold the quadrant onto the rising quarter.
    always_comb
    begin
        logic [30:0] r;
        r      = {1'b0, u_reg[29:0]};
        x_next = u_reg[30] ? Q30_ONE - r : r;
    end

    // Square of the reduced argument.
    always_comb
    begin
        logic [61:0] prod;
        prod    = 62'(x_reg) * 62'(x_reg);
        x2_next = prod[60:30];
    end

    // Horner steps, one multiply per stage.
    logic          hn_vld_in   [HORNER_N];
    logic [PB-1:0] hn_phase_in [HORNER_N];
    logic [1:0]    hn_quad_in  [HORNER_N];
    logic [30:0]   hn_x_in     [HORNER_N];
    logic [30:0]   hn_x2_in    [HORNER_N];
    logic [30:0]   hn_p_in     [HORNER_N];
    logic [61:0]   hn_prod     [HORNER_N];

    logic          hn_vld_reg   [HORNER_N];
    logic [PB-1:0] hn_phase_reg [HORNER_N];
    logic [1:0]    hn_quad_reg  [HORNER_N];
    logic [30:0]   hn_x_reg     [HORNER_N];
    logic [30:0]   hn_x2_reg    [HORNER_N];
    logic [30:0]   hn_p_reg     [HORNER_N];
    logic [30:0]   hn_p_next    [HORNER_N];

    for (genvar j = 0; j < HORNER_N; j++)
    begin : g_horner
        if (j == 0)
        begin : g_first
            assign hn_vld_in[j]   = x2_vld_reg;
            assign hn_phase_in[j] = x2_phase_reg;
            assign hn_quad_in[j]  = x2_quad_reg;
            assign hn_x_in[j]     = x2_x_reg;
            assign hn_x2_in[j]    = x2_reg;
            assign hn_p_in[j]     = SIN_C11;
        end
        else
        begin : g_next
            assign hn_vld_in[j]   = hn_vld_reg[j-1];
            assign hn_phase_in[j] = hn_phase_reg[j-1];
            assign hn_quad_in[j]  = hn_quad_reg[j-1];
            assign hn_x_in[j]     = hn_x_reg[j-1];
            assign hn_x2_in[j]    = hn_x2_reg[j-1];
            assign hn_p_in[j]     = hn_p_reg[j-1];
        end

        assign hn_prod[j]   = 62'(hn_x2_in[j]) * 62'(hn_p_in[j]);
        assign hn_p_next[j] = SIN_HORNER[j] - hn_prod[j][60:30];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hn_vld_reg[j] <= 1'b0;
            end
            else
            begin
                hn_vld_reg[j] <= hn_vld_in[j];
            end
        end

        always_ff @(posedge clk)
        begin
            hn_phase_reg[j] <= hn_phase_in[j];
            hn_quad_reg[j]  <= hn_quad_in[j];
            hn_x_reg[j]     <= hn_x_in[j];
            hn_x2_reg[j]    <= hn_x2_in[j];
            hn_p_reg[j]     <= hn_p_next[j];
        end
    end

    // ------------------------------------------------------------------
    // Sine value, unit level and mapping
    // ------------------------------------------------------------------
    logic          sn_vld_reg;
    logic [PB-1:0] sn_phase_reg;
    logic [1:0]    sn_quad_reg;
    logic [30:0]   sn_reg, sn_next;

    logic          w_vld_reg;
    logic          w_grav_hi_reg, w_grav_hi_next;
    logic [PB:0]   w_reg, w_next;
    logic [2*PB-1:0] w_sq_reg, w_sq_next;

    logic                 mul_vld_reg;
    logic [LEVEL_W+PB:0]  mul_reg, mul_next;
    logic [LEVEL_W-1:0]   mul_grav_reg, mul_grav_next;

    logic               done_reg;
    logic [LEVEL_W-1:0] wave_value_reg, wave_value_next;

    // Final polynomial product, capped at 1.0.
    always_comb
    begin
        logic [61:0] prod;
        prod    = 62'(hn_x_reg[HORNER_N-1]) * 62'(hn_p_reg[HORNER_N-1]);
        sn_next = (prod[60:30] > Q30_ONE) ? Q30_ONE : prod[60:30];
    end

    // Unit level for the selected waveform, plus the gravity square.
    always_comb
    begin
        logic [TIME_W-1:0] entry;
        logic [EW-1:0]     scaled;
        logic [PB:0]       ph;
        ph     = {1'b0, sn_phase_reg};
        entry  = sn_quad_reg[1] ? TIME_W'(Q30_ONE) - TIME_W'(sn_reg)
                                : TIME_W'(Q30_ONE) + TIME_W'(sn_reg);
        scaled = (EW'(entry) << PB) + (EW'(1) << 30);
        case (waveform_select_reg)
            WAVE_TRIANGLE: w_next = (sn_phase_reg > PHASE_HALF) ? (PHASE_ONE - ph) << 1
                                                                : ph << 1;
            WAVE_SQUARE:   w_next = (sn_phase_reg > PHASE_HALF) ? PHASE_ONE : '0;
            WAVE_SINE:     w_next = scaled[31 +: PB+1];
            WAVE_SAWTOOTH: w_next = ph;
            default:       w_next = '0;
        endcase
        w_grav_hi_next = (sn_phase_reg >= PHASE_HALF);
        w_sq_next      = (2*PB)'(sn_phase_reg) * (2*PB)'(sn_phase_reg);
    end

    // Span times level.
    assign mul_next = (LEVEL_W+PB+1)'(span_mag_reg) * (LEVEL_W+PB+1)'(w_reg);

    // Gravity: 4 * phase^2 in Q16.16, rounded half up, 1.0 past half a period.
    logic [LEVEL_W-1:0] grav_sq;
    if (GRAV_SH > 0)
    begin : g_grav_down
        logic [2*PB:0] grav_sum;
        assign grav_sum = {1'b0, w_sq_reg} + ((2*PB+1)'(1) << (GRAV_SH - 1));
        assign grav_sq  = LEVEL_W'(grav_sum >> GRAV_SH);
    end
    else if (GRAV_SH < 0)
    begin : g_grav_up
        assign grav_sq = LEVEL_W'(w_sq_reg) << (-GRAV_SH);
    end
    else
    begin : g_grav_same
        assign grav_sq = LEVEL_W'(w_sq_reg);
    end
    assign mul_grav_next = w_grav_hi_reg ? GRAVITY_ONE : grav_sq;

    // Round the mapped offset, apply it to the minimum and pick the result.
    always_comb
    begin
        logic [LEVEL_W+PB:0] sum;
        logic [LEVEL_W-1:0]  offs;
        logic [LEVEL_W-1:0]  mapped;
        sum    = mul_reg + (LEVEL_W+PB+1)'(PHASE_HALF);
        offs   = sum[PB +: LEVEL_W];
        mapped = span_neg_reg ? minimum_level_reg - offs : minimum_level_reg + offs;
        case (waveform_select_reg)
            WAVE_TRIANGLE: wave_value_next = mapped;
            WAVE_SQUARE:   wave_value_next = mapped;
            WAVE_SINE:     wave_value_next = mapped;
            WAVE_SAWTOOTH: wave_value_next = mapped;
            WAVE_GRAVITY:  wave_value_next = mul_grav_reg;
            default:       wave_value_next = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_vld_reg   <= 1'b0;
            kr_vld_reg  <= 1'b0;
            qd_vld_reg  <= 1'b0;
            u_vld_reg   <= 1'b0;
            x_vld_reg   <= 1'b0;
            x2_vld_reg  <= 1'b0;
            sn_vld_reg  <= 1'b0;
            w_vld_reg   <= 1'b0;
            mul_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            k_vld_reg   <= div_valid;
            kr_vld_reg  <= k_vld_reg;
            qd_vld_reg  <= kr_vld_reg;
            u_vld_reg   <= qd_vld_reg;
            x_vld_reg   <= u_vld_reg;
            x2_vld_reg  <= x_vld_reg;
            sn_vld_reg  <= hn_vld_reg[HORNER_N-1];
            w_vld_reg   <= sn_vld_reg;
            mul_vld_reg <= w_vld_reg;
            done_reg    <= mul_vld_reg;
        end
    end

    // Data.
    always_ff @(posedge clk)
    begin
        k_phase_reg    <= phase;
        k_reg          <= k_next;

        kr_phase_reg   <= k_phase_reg;
        kr_k_reg       <= k_reg;
        kr_reg         <= kr_next;

        qd_phase_reg   <= kr_phase_reg;
        qd_k_reg       <= kr_k_reg;
        qd_q0_reg      <= qd_q0_next;
        qd_reg         <= qd_next;

        u_phase_reg    <= qd_phase_reg;
        u_reg          <= u_next;

        x_phase_reg    <= u_phase_reg;
        x_quad_reg     <= u_reg[31:30];
        x_reg          <= x_next;

        x2_phase_reg   <= x_phase_reg;
        x2_quad_reg    <= x_quad_reg;
        x2_x_reg       <= x_reg;
        x2_reg         <= x2_next;

        sn_phase_reg   <= hn_phase_reg[HORNER_N-1];
        sn_quad_reg    <= hn_quad_reg[HORNER_N-1];
        sn_reg         <= sn_next;

        w_grav_hi_reg  <= w_grav_hi_next;
        w_reg          <= w_next;
        w_sq_reg       <= w_sq_next;

        mul_reg        <= mul_next;
        mul_grav_reg   <= mul_grav_next;

        wave_value_reg <= wave_value_next;
    end

    assign done       = done_reg;
    assign wave_value = $signed(wave_value_reg);

endmodule

// ===== src/pwg_checker.sv =====
// Port-level checker for the periodic waveform generator, bound to the top level.
// Depends on pwg_pkg and periodic_waveform_generator_macros.svh.
`include "periodic_waveform_generator_macros.svh"

module pwg_checker #(
    parameter int PHASE_BITS = 16
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               cfg_we,
    input logic [1:0]                         cfg_index,
    input logic [pwg_pkg::LEVEL_W-1:0]        cfg_wdata,
    input logic                               done,
    input logic signed [pwg_pkg::LEVEL_W-1:0] wave_value
);
    import pwg_pkg::*;

    localparam int LATENCY = PHASE_BITS + 47;
    localparam int CNT_W   = $clog2(LATENCY + 1);

    // Waveform code as last written, tracked from the register port.
    logic [2:0]       wave_sel_reg, wave_sel_next;
    // Edges since reset, saturating once the pipeline has filled.
    logic [CNT_W-1:0] since_rst_reg, since_rst_next;

    always_comb
    begin
        wave_sel_next  = (cfg_we && cfg_index == REG_WAVEFORM) ? cfg_wdata[2:0]
                                                               : wave_sel_reg;
        since_rst_next = (since_rst_reg == CNT_W'(LATENCY)) ? since_rst_reg
                                                             : since_rst_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_sel_reg  <= WAVE_RESET;
            since_rst_reg <= '0;
        end
        else
        begin
            wave_sel_reg  <= wave_sel_next;
            since_rst_reg <= since_rst_next;
        end
    end

    // Every request is taken.
    `PWG_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy, "request refused")

    // Each request gives exactly one strobe after the fixed latency.
    `PWG_ASSERT_IMPL(a_strobe_latency, clk, rst_n, since_rst_reg == CNT_W'(LATENCY), done == $past(start && !busy, LATENCY), "strobe does not match a request")

    // Unused waveform codes give zero.
    `PWG_ASSERT_IMPL(a_unused_zero, clk, rst_n, done && (wave_sel_reg > WAVE_GRAVITY), wave_value == '0, "unused waveform gave nonzero value")

    // Gravity never leaves 0 .. 1.0.
    `PWG_ASSERT_IMPL(a_gravity_range, clk, rst_n, done && (wave_sel_reg == WAVE_GRAVITY), $unsigned(wave_value) <= GRAVITY_ONE, "gravity above 1.0")

endmodule

bind periodic_waveform_generator pwg_checker #(
    .PHASE_BITS (PHASE_BITS)
) u_pwg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .done       (done),
    .wave_value (wave_value)
);
